// File: rtl/core/tres_pkg.sv
package tres_pkg;

    // field widths
    localparam int SYM_W    = 8;
    localparam int PER_IN_W = 10;
    localparam int CNT_W    = 16;
    localparam int SCORE_W  = CNT_W + 1;

    // sizing
    localparam int PERIOD_CAP = 512;
    localparam int HIST_DEPTH = 2 * PERIOD_CAP;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int FLAG_AW    = $clog2(PERIOD_CAP);
    localparam int P_W        = $clog2(PERIOD_CAP) + 1;
    localparam int P2_W       = P_W + 1;

    // position saturates here
    localparam logic [CNT_W-1:0] MAX_LENGTH = CNT_W'(65535);
    localparam logic [CNT_W-1:0] CNT_MAX    = {CNT_W{1'b1}};

    // divider: numerator is error_count shifted up by the fraction width
    localparam int NUM_W     = 2 * CNT_W;
    localparam int DIV_STEPS = NUM_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);
    localparam logic [SCORE_W-1:0] SCORE_ONE = SCORE_W'(1) << CNT_W;

endpackage

// File: rtl/core/tres_ram.sv
module tres_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: rtl/core/tandem_repeat_error_score.sv
// Tandem repeat error scorer. Symbols of one candidate repeat arrive one per
// transaction; s_first starts a run and samples s_period (0 counts as 1,
// values above 512 count as 512). Each symbol at position i >= p is compared
// with the one p back; from i >= 2p a mismatch is forgiven when the symbol
// equals the one 2p back and the comparison p earlier was not forgiven.
// A transaction with s_last set produces one result: saturating error count,
// span (length minus period) and the rounded score error_count/span in
// unsigned Q1.16, or too_short with zeros when length <= period.
// Timing: s_ready is high only in S_IDLE. A symbol that is compared passes
// through S_RD1, S_RD2, S_EVAL and S_WRH (history and flags live in
// single-port RAMs, so the two history reads, the flag read and both writes
// are sequenced); a symbol with no comparison passes through S_RD1 and S_WRH,
// and one past the length limit through S_RD1 only. A last symbol then adds
// S_FIN for setup, S_DIV for the radix-2 divider of the score, and S_OUT to
// load the output register. The result waits in the output register while
// new symbols are taken; a later result stalls only until it has been taken.
module tandem_repeat_error_score (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [tres_pkg::SYM_W-1:0]    s_symbol,
    input  logic [tres_pkg::PER_IN_W-1:0] s_period,
    input  logic                          s_first,
    input  logic                          s_last,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tres_pkg::CNT_W-1:0]    m_error_count,
    output logic [tres_pkg::CNT_W-1:0]    m_span,
    output logic [tres_pkg::SCORE_W-1:0]  m_score_q16,
    output logic                          m_too_short
);

    typedef enum logic [2:0] {
        S_IDLE, S_RD1, S_RD2, S_EVAL, S_WRH, S_FIN, S_DIV, S_OUT
    } state_t;

    state_t state_reg;

    // run state
    logic [tres_pkg::CNT_W-1:0]    pos_reg;
    logic [tres_pkg::CNT_W-1:0]    err_reg;
    logic [tres_pkg::PER_IN_W-1:0] held_reg;

    // current transaction
    logic [tres_pkg::SYM_W-1:0] sym_reg;
    logic                       last_reg;
    logic [tres_pkg::SYM_W-1:0] back1_reg;

    // divider
    logic [tres_pkg::NUM_W-1:0]   num_reg;
    logic [tres_pkg::CNT_W-1:0]   rem_reg;
    logic [tres_pkg::SCORE_W-1:0] quo_reg;
    logic [tres_pkg::DCNT_W-1:0]  dcnt_reg;

    // pending result
    logic [tres_pkg::CNT_W-1:0] res_err_reg;
    logic [tres_pkg::CNT_W-1:0] res_span_reg;
    logic                       res_short_reg;

    // output register
    logic                         m_valid_reg;
    logic [tres_pkg::CNT_W-1:0]   m_err_reg;
    logic [tres_pkg::CNT_W-1:0]   m_span_reg;
    logic [tres_pkg::SCORE_W-1:0] m_score_reg;
    logic                         m_short_reg;

    // effective period and derived positions
    logic [tres_pkg::P_W-1:0]   per_eff;
    logic [tres_pkg::P2_W-1:0]  two_p;
    logic [tres_pkg::CNT_W-1:0] per_ext;
    logic [tres_pkg::CNT_W-1:0] two_p_ext;
    logic [tres_pkg::CNT_W-1:0] back1_pos;
    logic [tres_pkg::CNT_W-1:0] back2_pos;
    logic                       pos_full;
    logic                       do_cmp;
    logic                       in_first_period;

    // comparison outcome
    logic [tres_pkg::SYM_W-1:0] hist_rdata;
    logic                       flag_rdata;
    logic                       mismatch;
    logic                       forgive;
    logic [tres_pkg::CNT_W-1:0] err_next;

    // ram ports
    logic                         hist_we;
    logic [tres_pkg::HIST_AW-1:0] hist_addr;
    logic                         flag_we;
    logic [tres_pkg::FLAG_AW-1:0] flag_addr;

    // divider step
    logic [tres_pkg::CNT_W:0]     trial;
    logic                         trial_ge;
    logic [tres_pkg::CNT_W-1:0]   span_calc;
    logic [tres_pkg::SCORE_W-1:0] score_sat;
    logic                         out_free;

    always_comb begin
        if (held_reg == '0) begin
            per_eff = tres_pkg::P_W'(1);
        end else if (held_reg > tres_pkg::PER_IN_W'(tres_pkg::PERIOD_CAP)) begin
            per_eff = tres_pkg::P_W'(tres_pkg::PERIOD_CAP);
        end else begin
            per_eff = tres_pkg::P_W'(held_reg);
        end
    end

    assign two_p           = {per_eff, 1'b0};
    assign per_ext         = tres_pkg::CNT_W'(per_eff);
    assign two_p_ext       = tres_pkg::CNT_W'(two_p);
    assign back1_pos       = pos_reg - per_ext;
    assign back2_pos       = pos_reg - two_p_ext;
    assign pos_full        = (pos_reg == tres_pkg::MAX_LENGTH);
    assign do_cmp          = !pos_full && (pos_reg >= per_ext);
    assign in_first_period = (pos_reg < two_p_ext);

    // back1 was captured in the previous state, back2 and the old flag
    // arrive from the rams now
    assign mismatch = (sym_reg != back1_reg);
    assign forgive  = mismatch && !in_first_period
                      && (sym_reg == hist_rdata) && !flag_rdata;

    always_comb begin
        err_next = err_reg;
        if (mismatch && !forgive && (err_reg != tres_pkg::CNT_MAX)) begin
            err_next = err_reg + 1'b1;
        end
    end

    // ram address sequencing
    always_comb begin
        hist_we   = 1'b0;
        flag_we   = 1'b0;
        hist_addr = pos_reg[tres_pkg::HIST_AW-1:0];
        flag_addr = back2_pos[tres_pkg::FLAG_AW-1:0];
        case (state_reg)
            S_RD1: begin
                hist_addr = back1_pos[tres_pkg::HIST_AW-1:0];
            end
            S_RD2: begin
                hist_addr = back2_pos[tres_pkg::HIST_AW-1:0];
                flag_addr = back2_pos[tres_pkg::FLAG_AW-1:0];
            end
            S_EVAL: begin
                // flag of this comparison, slot j mod PERIOD_CAP
                flag_we   = 1'b1;
                flag_addr = back1_pos[tres_pkg::FLAG_AW-1:0];
            end
            S_WRH: begin
                hist_we   = 1'b1;
                hist_addr = pos_reg[tres_pkg::HIST_AW-1:0];
            end
            default: begin
                hist_we = 1'b0;
            end
        endcase
    end

    tres_ram #(
        .WIDTH (tres_pkg::SYM_W),
        .DEPTH (tres_pkg::HIST_DEPTH)
    ) u_hist (
        .clk   (aclk),
        .we    (hist_we),
        .addr  (hist_addr),
        .wdata (sym_reg),
        .rdata (hist_rdata)
    );

    tres_ram #(
        .WIDTH (1),
        .DEPTH (tres_pkg::PERIOD_CAP)
    ) u_flag (
        .clk   (aclk),
        .we    (flag_we),
        .addr  (flag_addr),
        .wdata (forgive),
        .rdata (flag_rdata)
    );

    // restoring divider, one quotient bit per cycle
    assign trial     = {rem_reg, num_reg[tres_pkg::NUM_W-1]};
    assign trial_ge  = (trial >= {1'b0, res_span_reg});
    assign span_calc = pos_reg - per_ext;
    assign score_sat = (quo_reg > tres_pkg::SCORE_ONE) ? tres_pkg::SCORE_ONE : quo_reg;
    assign out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pos_reg     <= '0;
            err_reg     <= '0;
            held_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // output handshake, unless a new result is loaded this cycle
            if (m_valid_reg && m_ready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        sym_reg  <= s_symbol;
                        last_reg <= s_last;
                        if (s_first) begin
                            pos_reg  <= '0;
                            err_reg  <= '0;
                            held_reg <= s_period;
                        end
                        state_reg <= S_RD1;
                    end
                end
                S_RD1: begin
                    // history read of the symbol p back is issued here
                    if (pos_full) begin
                        // length cap: symbol ignored
                        state_reg <= last_reg ? S_FIN : S_IDLE;
                    end else if (do_cmp) begin
                        state_reg <= S_RD2;
                    end else begin
                        state_reg <= S_WRH;
                    end
                end
                S_RD2: begin
                    back1_reg <= hist_rdata;
                    state_reg <= S_EVAL;
                end
                S_EVAL: begin
                    err_reg   <= err_next;
                    state_reg <= S_WRH;
                end
                S_WRH: begin
                    pos_reg   <= pos_reg + 1'b1;
                    state_reg <= last_reg ? S_FIN : S_IDLE;
                end
                S_FIN: begin
                    rem_reg  <= '0;
                    quo_reg  <= '0;
                    dcnt_reg <= '0;
                    if (pos_reg <= per_ext) begin
                        res_err_reg   <= '0;
                        res_span_reg  <= '0;
                        res_short_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end else begin
                        res_err_reg   <= err_reg;
                        res_span_reg  <= span_calc;
                        res_short_reg <= 1'b0;
                        // numerator with half the divisor added for rounding
                        num_reg <= {err_reg, {tres_pkg::CNT_W{1'b0}}}
                                   + tres_pkg::NUM_W'(span_calc[tres_pkg::CNT_W-1:1]);
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    num_reg <= {num_reg[tres_pkg::NUM_W-2:0], 1'b0};
                    quo_reg <= {quo_reg[tres_pkg::SCORE_W-2:0], trial_ge};
                    if (trial_ge) begin
                        rem_reg <= tres_pkg::CNT_W'(trial - {1'b0, res_span_reg});
                    end else begin
                        rem_reg <= trial[tres_pkg::CNT_W-1:0];
                    end
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (dcnt_reg == tres_pkg::DCNT_W'(tres_pkg::DIV_STEPS - 1)) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_err_reg   <= res_err_reg;
                        m_span_reg  <= res_span_reg;
                        m_score_reg <= score_sat;
                        m_short_reg <= res_short_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_error_count = m_err_reg;
    assign m_span        = m_span_reg;
    assign m_score_q16   = m_score_reg;
    assign m_too_short   = m_short_reg;

endmodule
